### rtl/spms_pkg.sv
// Package for the shared-pool multi-stack: sizes, pointer widths, codes and
// the command group between controller and datapath. No dependencies.
`default_nettype none

package spms_pkg;

  // Pool and stack sizing
  localparam int unsigned NUM_STACKS = 4;
  localparam int unsigned POOL_SLOTS = 16;

  // Field widths
  localparam int unsigned SID_W = 2;
  localparam int unsigned VAL_W = 32;

  // Slot index addresses the pool; a pointer also holds the null code
  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned PTR_W = $clog2(POOL_SLOTS + 1);

  localparam logic [PTR_W-1:0] NULL_PTR    = PTR_W'(POOL_SLOTS);
  localparam logic [VAL_W-1:0] EMPTY_VALUE = 32'h7FFF_FFFF;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // input transfer: latch op, launch slot reads
    logic commit;  // update pointers and load the result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### rtl/spms_ctrl.sv
// Controller for the shared-pool multi-stack: two-state sequencer and the
// result valid flag. Depends on spms_pkg.
`default_nettype none

module spms_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output spms_pkg::ctrl_cmd_t     cmd_o
);

  spms_pkg::fsm_e state_q, state_d;
  logic           out_valid_q, out_valid_d;

  // State and valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spms_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands; accept only when the result register will be
  // free by the time this op commits
  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      spms_pkg::FSM_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = spms_pkg::FSM_EXEC;
        end
      end
      spms_pkg::FSM_EXEC: begin
        cmd_o.commit = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = spms_pkg::FSM_IDLE;
      end
      default: begin
        state_d = spms_pkg::FSM_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/spms_dp.sv
// Datapath for the shared-pool multi-stack: slot value and link memories,
// stack top and free head registers, result register. Depends on spms_pkg.
`default_nettype none

module spms_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire spms_pkg::ctrl_cmd_t           cmd_i,
  input  wire logic                          command_i,
  input  wire logic [spms_pkg::SID_W-1:0]    stack_id_i,
  input  wire logic signed [spms_pkg::VAL_W-1:0] push_value_i,
  output logic signed [spms_pkg::VAL_W-1:0]  pop_value_o,
  output logic [1:0]                         status_o,
  output logic                               pool_full_o,
  output logic                               stack_empty_o
);

  // Storage
  logic [spms_pkg::VAL_W-1:0] val_mem [spms_pkg::POOL_SLOTS];
  logic [spms_pkg::PTR_W-1:0] link_mem [spms_pkg::POOL_SLOTS];
  logic [spms_pkg::POOL_SLOTS-1:0] link_vld_q;
  logic [spms_pkg::PTR_W-1:0] tops_q [spms_pkg::NUM_STACKS];
  logic [spms_pkg::PTR_W-1:0] free_q;

  // Latched operation
  logic                        op_pop_q;
  logic                        op_fail_q;
  logic                        op_sid_ok_q;
  logic [spms_pkg::SID_W-1:0]  op_sid_q;
  logic [spms_pkg::PTR_W-1:0]  op_slot_q;
  logic [spms_pkg::PTR_W-1:0]  link_rd_q;
  logic [spms_pkg::VAL_W-1:0]  val_rd_q;

  // Result register
  logic [spms_pkg::VAL_W-1:0]  res_val_q, res_val_d;
  logic [1:0]                  res_st_q, res_st_d;
  logic                        res_full_q, res_full_d;
  logic                        res_empty_q, res_empty_d;

  // Load-cycle decode
  logic                        sid_ok;
  logic                        in_pop;
  logic [spms_pkg::PTR_W-1:0]  top_sel;
  logic [spms_pkg::PTR_W-1:0]  ptr_sel;
  logic                        ptr_null;
  logic [spms_pkg::IDX_W-1:0]  rd_idx;

  // Commit-cycle next pointers
  logic [spms_pkg::PTR_W-1:0]  free_d;
  logic [spms_pkg::PTR_W-1:0]  top_d;
  logic [spms_pkg::PTR_W-1:0]  op_top;
  logic [spms_pkg::PTR_W-1:0]  link_wr;
  logic [spms_pkg::IDX_W-1:0]  slot_idx;

  assign sid_ok  = 32'(stack_id_i) < spms_pkg::NUM_STACKS;
  assign in_pop  = (command_i == spms_pkg::CMD_POP);
  assign top_sel = sid_ok ? tops_q[stack_id_i] : spms_pkg::NULL_PTR;
  assign ptr_sel = in_pop ? top_sel : free_q;
  assign ptr_null = (32'(ptr_sel) >= spms_pkg::POOL_SLOTS);
  assign rd_idx  = ptr_sel[spms_pkg::IDX_W-1:0];

  // Op latch; reads of the chosen slot launch with the transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_pop_q    <= in_pop;
      op_fail_q   <= !sid_ok || ptr_null;
      op_sid_ok_q <= sid_ok;
      op_sid_q    <= stack_id_i;
      op_slot_q   <= ptr_sel;
      val_rd_q    <= val_mem[rd_idx];
      link_rd_q   <= link_vld_q[rd_idx] ? link_mem[rd_idx]
                                        : spms_pkg::PTR_W'(rd_idx) + 1'b1;
    end
  end

  // Value memory: a push stores at the free head straight away
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !in_pop && sid_ok && !ptr_null) begin
      val_mem[rd_idx] <= push_value_i;
    end
  end

  // Commit: relink pointers
  assign op_top   = op_sid_ok_q ? tops_q[op_sid_q] : spms_pkg::NULL_PTR;
  assign slot_idx = op_slot_q[spms_pkg::IDX_W-1:0];

  always_comb begin
    free_d  = free_q;
    top_d   = op_top;
    link_wr = op_top;
    if (!op_fail_q) begin
      if (op_pop_q) begin
        top_d   = link_rd_q;
        link_wr = free_q;
        free_d  = op_slot_q;
      end else begin
        free_d  = link_rd_q;
        link_wr = op_top;
        top_d   = op_slot_q;
      end
    end
  end

  // Link memory; valid bits stand in for the reset chain
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !op_fail_q) begin
      link_mem[slot_idx] <= link_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      free_q     <= '0;
      for (int i = 0; i < int'(spms_pkg::NUM_STACKS); i++) begin
        tops_q[i] <= spms_pkg::NULL_PTR;
      end
    end else if (cmd_i.commit && !op_fail_q) begin
      link_vld_q[slot_idx] <= 1'b1;
      free_q               <= free_d;
      tops_q[op_sid_q]     <= top_d;
    end
  end

  // Result fields
  always_comb begin
    res_val_d = '0;
    res_st_d  = spms_pkg::ST_OK;
    if (op_pop_q) begin
      res_val_d = op_fail_q ? spms_pkg::EMPTY_VALUE : val_rd_q;
      if (op_fail_q) res_st_d = spms_pkg::ST_EMPTY;
    end else if (op_fail_q) begin
      res_st_d = spms_pkg::ST_OVERFLOW;
    end
    res_full_d  = 32'(free_d) >= spms_pkg::POOL_SLOTS;
    res_empty_d = !op_sid_ok_q || (32'(top_d) >= spms_pkg::POOL_SLOTS);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_val_q   <= res_val_d;
      res_st_q    <= res_st_d;
      res_full_q  <= res_full_d;
      res_empty_q <= res_empty_d;
    end
  end

  assign pop_value_o   = res_val_q;
  assign status_o      = res_st_q;
  assign pool_full_o   = res_full_q;
  assign stack_empty_o = res_empty_q;

endmodule

`default_nettype wire

### rtl/shared_pool_multi_stack.sv
// Top level of the shared-pool multi-stack: controller plus datapath.
// Depends on spms_pkg, spms_ctrl and spms_dp.
//
// Four LIFO stacks share a pool of 16 slots held as linked chains, with the
// unused slots on a free chain. Each transfer in gives one result: push
// (command 0) or pop (command 1) on stack_id. An operation has a load step
// that reads the top or free-head pointer and then its link from the link
// memory, and a commit step; no new transfer is taken before the commit.
// The result sits in an output register, so the next operation is taken in
// the same cycle as the held result is transferred out. No clearing pass is
// needed after reset.
`default_nettype none

module shared_pool_multi_stack (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              command_i,
  input  wire logic [spms_pkg::SID_W-1:0]        stack_id_i,
  input  wire logic signed [spms_pkg::VAL_W-1:0] push_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [spms_pkg::VAL_W-1:0]      pop_value_o,
  output logic [1:0]                             status_o,
  output logic                                   pool_full_o,
  output logic                                   stack_empty_o
);

  spms_pkg::ctrl_cmd_t cmd;

  spms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spms_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (command_i),
    .stack_id_i    (stack_id_i),
    .push_value_i  (push_value_i),
    .pop_value_o   (pop_value_o),
    .status_o      (status_o),
    .pool_full_o   (pool_full_o),
    .stack_empty_o (stack_empty_o)
  );

endmodule

`default_nettype wire
